FILE: rtl/bdq_pkg.sv
// Shared package for the bounded deque: widths, action codes and controller states.
// No dependencies; every other file of the block imports it.
package bdq_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W = 5;
  localparam int ACT_W = 3;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);
  localparam logic signed [DATA_W-1:0] NEG_ONE = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_QUERY      = 3'd4
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

FILE: rtl/bdq_if.sv
// Request and response channel interfaces of the bounded deque.
// Depends on bdq_pkg for field widths.
interface bdq_in_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface bdq_out_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] popped;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;

  modport source (output valid, output ok, output popped, output count,
                  output front_value, output back_value, input ready);
  modport sink   (input valid, input ok, input popped, input count,
                  input front_value, input back_value, output ready);
endinterface

FILE: rtl/bdq_ram.sv
// Slot storage of the bounded deque: one write port, two registered read ports.
// Depends on bdq_pkg; a read of the entry being written returns the new data.
module bdq_ram import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr_a,
  input  logic [AW-1:0]            raddr_b,
  output logic signed [DATA_W-1:0] rdata_a,
  output logic signed [DATA_W-1:0] rdata_b
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Forward the write data when a read hits the entry written in the same cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
      rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
    end
  end

endmodule

FILE: rtl/bounded_deque.sv
// Top level of the bounded deque: pointer and count control, capacity register,
// response register. Depends on bdq_pkg, bdq_if and bdq_ram.
//
//   channel  dir  handshake          payload
//   req      in   valid / ready      action[2:0], value[31:0] signed
//   rsp      out  valid / ready      ok, popped, count[4:0], front_value, back_value
//   cfg      in   cfg_we             cfg_data[4:0] -> capacity
//
// In each transaction the accept cycle updates the pointers and the count and
// writes a pushed value, and then the registered read of the slot memory
// delivers the new front and back entries. The response register lets the next
// request be taken while a response still waits. A stalled response holds the
// controller in its read state. Reset (synchronous) empties the deque and sets
// capacity to 16; slot contents are left as they are.
module bounded_deque import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  bdq_in_if.sink           req,
  bdq_out_if.source        rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  // Ring pointer arithmetic; the pointers stay below DEPTH.
  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
    return (x == LAST) ? '0 : x + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] x);
    return (x == '0) ? LAST : x - AW'(1);
  endfunction

  state_t state, state_next;

  logic [CNT_W-1:0]         capacity;
  logic [AW-1:0]            head, head_next;     // slot of the front entry
  logic [AW-1:0]            tail, tail_next;     // slot of the back entry
  logic [CNT_W-1:0]         count, count_next;
  logic signed [DATA_W-1:0] front_q, back_q;     // cached front and back entries
  logic                     ok_q, ok_next;
  logic signed [DATA_W-1:0] popped_q, popped_next;

  logic                     accept;
  logic                     load_out;
  logic                     at_cap;
  logic                     empty;
  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [DATA_W-1:0] rdata_a, rdata_b;

  assign accept = req.valid && req.ready;
  assign empty  = (count == '0);
  // Effective capacity saturates at DEPTH; a lowered capacity drops nothing.
  assign at_cap = (count >= capacity) || (int'(count) >= DEPTH);

  // Work out the action: move one pointer, adjust the count, pick the write.
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    ok_next     = 1'b0;
    popped_next = NEG_ONE;
    we          = 1'b0;
    waddr       = tail;
    case (action_t'(req.action))
      ACT_PUSH_BACK: begin
        if (!at_cap) begin
          tail_next  = ring_inc(tail);
          waddr      = tail_next;
          we         = accept;
          count_next = count + CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      ACT_PUSH_FRONT: begin
        if (!at_cap) begin
          head_next  = ring_dec(head);
          waddr      = head_next;
          we         = accept;
          count_next = count + CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (!empty) begin
          popped_next = front_q;
          head_next   = ring_inc(head);
          count_next  = count - CNT_W'(1);
          ok_next     = 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (!empty) begin
          popped_next = back_q;
          tail_next   = ring_dec(tail);
          count_next  = count - CNT_W'(1);
          ok_next     = 1'b1;
        end
      end
      default: begin
        // query only, and codes that mean nothing: leave the state alone
      end
    endcase
  end

  // Read the new front and back slots in the accept cycle; data lands next cycle.
  bdq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (req.value),
    .re      (accept),
    .raddr_a (head_next),
    .raddr_b (tail_next),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    req.ready = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_READ: load_out  = !rsp.valid || rsp.ready;
      default: begin
        req.ready = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      capacity <= CAP_RESET;
      head     <= '0;
      tail     <= LAST;
      count    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
  end

  // Hold the outcome of the action until the read data arrives.
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_q     <= ok_next;
      popped_q <= popped_next;
    end
    if (load_out) begin
      front_q <= rdata_a;
      back_q  <= rdata_b;
    end
  end

  // Response register: drop valid once taken, advance on a new result.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.ok          <= ok_q;
      rsp.popped      <= popped_q;
      rsp.count       <= count;
      rsp.front_value <= empty ? NEG_ONE : rdata_a;
      rsp.back_value  <= empty ? NEG_ONE : rdata_b;
    end
  end

endmodule
